FILE: src/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants
// Location codes, widths and the edge-test result returned by the edge unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pip_pkg;
    localparam int TOL_WIDTH = 21;
    localparam int LOC_WIDTH = 3;
    localparam int SUM_WIDTH = 18;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 21'd7;

    localparam logic [LOC_WIDTH-1:0] LOC_SHORT   = 3'd0;
    localparam logic [LOC_WIDTH-1:0] LOC_OUTSIDE = 3'd1;
    localparam logic [LOC_WIDTH-1:0] LOC_VERTEX  = 3'd2;
    localparam logic [LOC_WIDTH-1:0] LOC_EDGE    = 3'd3;
    localparam logic [LOC_WIDTH-1:0] LOC_INSIDE  = 3'd4;

    // edge unit outcome
    typedef struct packed {
        logic                 fixed;   // verdict found
        logic [LOC_WIDTH-1:0] code;
        logic [1:0]           add_en;  // add_en[0]: add to sum
        logic signed [2:0]    add;
    } edge_res_t;
endpackage
`default_nettype wire

FILE: src/pip_if.sv
// ----------------------------------------------------------------------------
// pip_vertex_if / pip_loc_if: valid-ready channels
// Vertex request channel and location result channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface pip_vertex_if #(parameter int COORD_WIDTH = 48);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic first_vertex;
    logic last_vertex;
    modport source (output valid, vertex_x, vertex_y, query_x, query_y,
                    first_vertex, last_vertex, input ready);
    modport sink (input valid, vertex_x, vertex_y, query_x, query_y,
                  first_vertex, last_vertex, output ready);
endinterface

interface pip_loc_if;
    logic valid;
    logic ready;
    logic [2:0] location;
    modport source (output valid, location, input ready);
    modport sink (input valid, location, output ready);
endinterface
`default_nettype wire

FILE: src/pip_edge.sv
// ----------------------------------------------------------------------------
// pip_edge: one edge test
// Compares are combinational; the cross products go through one shared
// multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pip_edge #(
    parameter int COORD_WIDTH = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [COORD_WIDTH-1:0] xi,
    input  wire logic signed [COORD_WIDTH-1:0] yi,
    input  wire logic signed [COORD_WIDTH-1:0] xj,
    input  wire logic signed [COORD_WIDTH-1:0] yj,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic [pip_pkg::TOL_WIDTH-1:0] tol,
    output logic done,
    output pip_pkg::edge_res_t res
);
    localparam int MW = COORD_WIDTH + 1;     // difference magnitude width
    localparam int HW = 32;
    localparam int PW = 2 * 64;              // product width (magnitudes padded to 64)
    localparam int EW = PW + 2;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DONE} state_t;
    typedef logic [MW-1:0] mag_t;

    // differences
    function automatic mag_t absd(input logic signed [COORD_WIDTH-1:0] a,
                                  input logic signed [COORD_WIDTH-1:0] b);
        logic signed [MW-1:0] d;
        d = MW'(a) - MW'(b);
        return d[MW-1] ? mag_t'(-d) : mag_t'(d);
    endfunction

    logic signed [COORD_WIDTH-1:0] xmin, xmax, ymin, ymax;
    mag_t m_dyi, m_dyj, m_dij, m_pxmin, m_pxmax, m_pxi, m_pxj, m_dx, m_dxp;
    logic [MW-1:0] tolx;
    logic n_dyi, n_dyj, n_dij, early;
    logic signed [2:0] add_c;
    pip_pkg::edge_res_t imm;
    logic need_mul;
    logic s_dyi, s_dx, s_dxp, s_dy;

    always_comb
    begin
        xmin = (xi < xj) ? xi : xj;
        xmax = (xi < xj) ? xj : xi;
        ymin = (yi < yj) ? yi : yj;
        ymax = (yi < yj) ? yj : yi;
        tolx = MW'(tol);
        m_dyi = absd(py, yi);
        m_dyj = absd(py, yj);
        m_dij = absd(yi, yj);
        m_pxmin = absd(px, xmin);
        m_pxmax = absd(px, xmax);
        m_pxi = absd(px, xi);
        m_pxj = absd(px, xj);
        m_dx = absd(xj, xi);
        m_dxp = absd(xi, px);
        s_dyi = py < yi;
        s_dx = xj < xi;
        s_dxp = xi < px;
        s_dy = yj < yi;
        n_dyi = m_dyi < tolx;
        n_dyj = m_dyj < tolx;
        n_dij = m_dij < tolx;
        add_c = (n_dyi ? 3'sd0 : (py > yi ? 3'sd1 : -3'sd1))
              + (n_dyj ? 3'sd0 : (yj > py ? 3'sd1 : -3'sd1));
        early = (py > ymax && absd(py, ymax) > tolx)
             || (py < ymin && absd(py, ymin) > tolx)
             || (px > xmax && m_pxmax > tolx);
        imm = '0;
        imm.add = add_c;
        need_mul = 1'b0;
        if (!early)
        begin
            if (n_dyi || n_dyj)
            begin
                if (n_dij)
                begin
                    if (m_pxmin < tolx || m_pxmax < tolx)
                    begin
                        imm.fixed = 1'b1;
                        imm.code = pip_pkg::LOC_VERTEX;
                    end
                    else if (px > xmin && px < xmax)
                    begin
                        imm.fixed = 1'b1;
                        imm.code = pip_pkg::LOC_EDGE;
                    end
                end
                else if (n_dyi)
                begin
                    if (m_pxi < tolx)
                    begin
                        imm.fixed = 1'b1;
                        imm.code = pip_pkg::LOC_VERTEX;
                    end
                    else
                        imm.add_en[0] = px < xi;
                end
                else if (m_pxj < tolx)
                begin
                    imm.fixed = 1'b1;
                    imm.code = pip_pkg::LOC_VERTEX;
                end
                else
                    imm.add_en[0] = px < xj;
            end
            else if (py > ymin && py < ymax)
            begin
                if (px < xmin && m_pxmin > tolx)
                    imm.add_en[0] = 1'b1;
                else
                    need_mul = 1'b1;
            end
        end
    end

    // shared multiplier: operand pairs for three products, four partials each
    state_t state_reg;
    logic [3:0] step_reg;
    logic [63:0] a_reg [3];
    logic [63:0] b_reg [3];
    logic [2:0] sg_reg;                    // 1 = negative
    logic [PW-1:0] acc_reg [3];
    pip_pkg::edge_res_t res_reg;
    logic [HW-1:0] opa, opb;
    logic [2*HW-1:0] prod_reg;
    logic [3:0] pstep_reg;
    logic pvalid_reg;
    logic [1:0] k;

    always_comb
    begin
        k = 2'(step_reg >> 2);
        opa = step_reg[0] ? a_reg[k][63:32] : a_reg[k][31:0];
        opb = step_reg[1] ? b_reg[k][63:32] : b_reg[k][31:0];
    end

    logic signed [EW-1:0] e0, e1, e;
    logic [EW-1:0] emag;
    logic pos;
    always_comb
    begin
        e0 = sg_reg[0] ? -EW'(acc_reg[0]) : EW'(acc_reg[0]);
        e1 = sg_reg[1] ? -EW'(acc_reg[1]) : EW'(acc_reg[1]);
        e = e0 + e1;
        emag = e[EW-1] ? EW'(-e) : EW'(e);
        pos = !e[EW-1] && (e != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            pvalid_reg <= 1'b0;
            done <= 1'b0;
            res_reg <= '0;
            sg_reg <= '0;
            prod_reg <= '0;
            pstep_reg <= '0;
            for (int n = 0; n < 3; n++)
            begin
                a_reg[n] <= '0;
                b_reg[n] <= '0;
                acc_reg[n] <= '0;
            end
        end
        else
        begin
            done <= 1'b0;
            pvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        res_reg <= imm;
                        if (need_mul)
                        begin
                            a_reg[0] <= 64'(m_dyi);
                            b_reg[0] <= 64'(m_dx);
                            sg_reg[0] <= (s_dy ^ s_dyi ^ s_dx);
                            a_reg[1] <= 64'(m_dxp);
                            b_reg[1] <= 64'(absd(yj, yi));
                            sg_reg[1] <= s_dxp;
                            a_reg[2] <= 64'(tol);
                            b_reg[2] <= 64'(absd(yj, yi));
                            sg_reg[2] <= 1'b0;
                            acc_reg[0] <= '0;
                            acc_reg[1] <= '0;
                            acc_reg[2] <= '0;
                            step_reg <= '0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            done <= 1'b1;
                        end
                    end
                end
                S_MUL:
                begin
                    if (step_reg != 4'd12)
                    begin
                        prod_reg <= opa * opb;
                        pstep_reg <= step_reg;
                        pvalid_reg <= 1'b1;
                        step_reg <= step_reg + 4'd1;
                    end
                    if (pvalid_reg)
                        acc_reg[2'(pstep_reg >> 2)] <= acc_reg[2'(pstep_reg >> 2)]
                            + (PW'(prod_reg) << (32 * (32'(pstep_reg[0]) + 32'(pstep_reg[1]))));
                    if (step_reg == 4'd12 && !pvalid_reg)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (emag < EW'(acc_reg[2]))
                    begin
                        res_reg.fixed <= 1'b1;
                        res_reg.code <= pip_pkg::LOC_EDGE;
                    end
                    else
                        res_reg.add_en[0] <= pos;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

FILE: src/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: ray-crossing point-in-polygon test
// Streams polygon vertices, tests each edge against the held query point and
// gives one location per polygon on its last vertex.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  vin       | in  | vertex_x, vertex_y, query_x, query_y, first/last_vertex
//  loc       | out | location
//  cfg       | in  | tolerance write (cfg_we, cfg_data)
//
// A vertex whose edge is settled by compares alone needs no multiplier; one
// that needs the three cross products waits while one 32x32 multiplier serves
// twelve partial products. A last vertex runs the closing edge as well,
// unless a verdict is already fixed.
// vin.ready is low while an edge runs and while a finished polygon waits
// for the previous location to leave loc.
// Reset clears all control state; tolerance resets to 7.
// ----------------------------------------------------------------------------
`default_nettype none
module point_in_polygon_test #(
    parameter int COORD_WIDTH = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pip_vertex_if.sink vin,
    pip_loc_if.source loc,
    input  wire logic cfg_we,
    input  wire logic [pip_pkg::TOL_WIDTH-1:0] cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_EDGE, S_CLOSE, S_OUT} state_t;
    typedef logic signed [COORD_WIDTH-1:0] crd_t;

    state_t state_reg;
    logic [pip_pkg::TOL_WIDTH-1:0] tol_reg;
    crd_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg, qx_reg, qy_reg;
    crd_t vx_reg, vy_reg;
    logic [pip_pkg::SUM_WIDTH-1:0] sum_reg;
    logic [1:0] seen_reg;
    logic fixed_reg;
    logic [pip_pkg::LOC_WIDTH-1:0] code_reg;
    logic last_reg, start_reg, loc_valid_reg;
    logic [pip_pkg::LOC_WIDTH-1:0] loc_reg;

    crd_t exi, eyi, exj, eyj;
    logic e_done;
    pip_pkg::edge_res_t e_res;

    // edge operands: closing edge runs last -> first
    always_comb
    begin
        if (state_reg == S_CLOSE)
        begin
            exi = vx_reg; eyi = vy_reg; exj = first_x_reg; eyj = first_y_reg;
        end
        else
        begin
            exi = prev_x_reg; eyi = prev_y_reg; exj = vx_reg; eyj = vy_reg;
        end
    end

    pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
        .clk(clk), .rst_n(rst_n), .start(start_reg),
        .xi(exi), .yi(eyi), .xj(exj), .yj(eyj), .px(qx_reg), .py(qy_reg),
        .tol(tol_reg), .done(e_done), .res(e_res)
    );

    assign vin.ready = (state_reg == S_IDLE);
    assign loc.valid = loc_valid_reg;
    assign loc.location = loc_reg;

    logic fixed_now;
    logic [pip_pkg::LOC_WIDTH-1:0] code_now;
    logic [pip_pkg::SUM_WIDTH-1:0] sum_now;
    always_comb
    begin
        fixed_now = fixed_reg;
        code_now = code_reg;
        sum_now = sum_reg;
        if (e_res.fixed)
        begin
            fixed_now = 1'b1;
            code_now = e_res.code;
        end
        else if (e_res.add_en[0])
            sum_now = sum_reg + pip_pkg::SUM_WIDTH'(e_res.add);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tol_reg <= pip_pkg::TOL_RESET;
            sum_reg <= '0;
            seen_reg <= '0;
            fixed_reg <= 1'b0;
            code_reg <= '0;
            first_x_reg <= '0; first_y_reg <= '0;
            prev_x_reg <= '0; prev_y_reg <= '0;
            qx_reg <= '0; qy_reg <= '0;
            vx_reg <= '0; vy_reg <= '0;
            last_reg <= 1'b0;
            loc_reg <= '0;
            start_reg <= 1'b0;
            loc_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_we)
                tol_reg <= cfg_data;
            if (loc_valid_reg && loc.ready)
                loc_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (vin.valid)
                    begin
                        vx_reg <= vin.vertex_x;
                        vy_reg <= vin.vertex_y;
                        last_reg <= vin.last_vertex;
                        if (vin.first_vertex || seen_reg == 2'd0)
                        begin
                            first_x_reg <= vin.vertex_x; prev_x_reg <= vin.vertex_x;
                            first_y_reg <= vin.vertex_y; prev_y_reg <= vin.vertex_y;
                            qx_reg <= vin.query_x; qy_reg <= vin.query_y;
                            sum_reg <= '0;
                            fixed_reg <= 1'b0;
                            code_reg <= '0;
                            seen_reg <= 2'd1;
                            state_reg <= vin.last_vertex ? S_OUT : S_IDLE;
                        end
                        else
                        begin
                            if (seen_reg != 2'd3)
                                seen_reg <= seen_reg + 2'd1;
                            if (fixed_reg)
                            begin
                                prev_x_reg <= vin.vertex_x; prev_y_reg <= vin.vertex_y;
                                state_reg <= vin.last_vertex ? S_OUT : S_IDLE;
                            end
                            else
                            begin
                                start_reg <= 1'b1;
                                state_reg <= S_EDGE;
                            end
                        end
                    end
                end
                S_EDGE:
                begin
                    if (e_done)
                    begin
                        fixed_reg <= fixed_now;
                        code_reg <= code_now;
                        sum_reg <= sum_now;
                        prev_x_reg <= vx_reg; prev_y_reg <= vy_reg;
                        if (last_reg && !fixed_now)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= S_CLOSE;
                        end
                        else
                            state_reg <= last_reg ? S_OUT : S_IDLE;
                    end
                end
                S_CLOSE:
                begin
                    if (e_done)
                    begin
                        fixed_reg <= fixed_now;
                        code_reg <= code_now;
                        sum_reg <= sum_now;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!loc_valid_reg)
                    begin
                        loc_valid_reg <= 1'b1;
                        if (seen_reg != 2'd3)
                            loc_reg <= pip_pkg::LOC_SHORT;
                        else if (fixed_reg)
                            loc_reg <= code_reg;
                        else
                            loc_reg <= (sum_reg == '0) ? pip_pkg::LOC_OUTSIDE
                                                       : pip_pkg::LOC_INSIDE;
                        seen_reg <= 2'd0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // hold the result until taken
    a_loc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        loc_valid_reg && !loc.ready |=> loc_valid_reg && $stable(loc_reg))
        else $error("location dropped while stalled");
    // never take a vertex while an edge runs
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDGE || state_reg == S_CLOSE) |-> !vin.ready)
        else $error("ready during edge test");
    // a fixed verdict is on vertex or on edge
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        fixed_reg |-> (code_reg == pip_pkg::LOC_VERTEX || code_reg == pip_pkg::LOC_EDGE))
        else $error("bad fixed code");
endmodule
`default_nettype wire

FILE: test/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker: location predictor and scoreboard
// Watches the vertex, location and tolerance ports, predicts each location
// with exact wide arithmetic and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module pip_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pip_vertex_if                              vin,
    pip_loc_if                                 loc,
    input  wire logic                          cfg_we,
    input  wire logic [pip_pkg::TOL_WIDTH-1:0] cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    typedef logic signed [131:0] wide_t;

    logic [pip_pkg::LOC_WIDTH-1:0] loc_queue[$];
    longint                        tol;
    longint                        poly_x0, poly_y0, last_x, last_y, ref_x, ref_y;
    logic [pip_pkg::SUM_WIDTH-1:0] winding;
    int                            vcount;
    logic                          settled;
    logic [pip_pkg::LOC_WIDTH-1:0] settled_code;

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit close(longint a, longint b);
        return mag(a - b) < tol;
    endfunction

    function automatic int tsgn(longint a, longint b);
        return close(a, b) ? 0 : sgn(a - b);
    endfunction

    function automatic void add_step(int step);
        winding = winding + pip_pkg::SUM_WIDTH'(step);
    endfunction

    function automatic void expect_loc(logic [pip_pkg::LOC_WIDTH-1:0] code);
        loc_queue = {loc_queue, code};
    endfunction

    function automatic logic [pip_pkg::LOC_WIDTH-1:0] edge_code(longint xi, longint yi,
                                                                longint xj, longint yj);
        longint xmin, xmax, ymin, ymax, px, py;
        int     step;
        wide_t  e, bound;
        px = ref_x;
        py = ref_y;
        xmin = (xi < xj) ? xi : xj;
        xmax = (xi < xj) ? xj : xi;
        ymin = (yi < yj) ? yi : yj;
        ymax = (yi < yj) ? yj : yi;
        if ((py - ymax > tol) || (ymin - py > tol) || (px - xmax > tol))
            return pip_pkg::LOC_SHORT;
        step = tsgn(py, yi) + tsgn(yj, py);
        if (close(py, yi) || close(py, yj))
        begin
            if (close(yi, yj))
            begin
                if (close(px, xmin) || close(px, xmax))
                    return pip_pkg::LOC_VERTEX;
                if (px > xmin && px < xmax)
                    return pip_pkg::LOC_EDGE;
                return pip_pkg::LOC_SHORT;
            end
            if (close(py, yi))
            begin
                if (close(px, xi))
                    return pip_pkg::LOC_VERTEX;
                if (px < xi)
                    add_step(step);
                return pip_pkg::LOC_SHORT;
            end
            if (close(px, xj))
                return pip_pkg::LOC_VERTEX;
            if (px < xj)
                add_step(step);
            return pip_pkg::LOC_SHORT;
        end
        if (py > ymin && py < ymax)
        begin
            if (xmin - px > tol)
            begin
                add_step(step);
                return pip_pkg::LOC_SHORT;
            end
            // crossing abscissa minus px, scaled by |yj - yi|
            e = wide_t'(py - yi) * wide_t'(xj - xi);
            if (yj < yi)
                e = -e;
            e = e + wide_t'(xi - px) * wide_t'(mag(yj - yi));
            bound = wide_t'(tol) * wide_t'(mag(yj - yi));
            if (((e < 0) ? -e : e) < bound)
                return pip_pkg::LOC_EDGE;
            if (e > 0)
                add_step(step);
        end
        return pip_pkg::LOC_SHORT;
    endfunction

    function automatic void visit_edge(longint xi, longint yi, longint xj, longint yj);
        logic [pip_pkg::LOC_WIDTH-1:0] c;
        if (settled)
            return;
        c = edge_code(xi, yi, xj, yj);
        if (c != pip_pkg::LOC_SHORT)
        begin
            settled = 1'b1;
            settled_code = c;
        end
    endfunction

    function automatic void take_vertex();
        longint vx, vy;
        vx = longint'(vin.vertex_x);
        vy = longint'(vin.vertex_y);
        if (vin.first_vertex || vcount == 0)
        begin
            poly_x0 = vx;
            poly_y0 = vy;
            last_x = vx;
            last_y = vy;
            ref_x = longint'(vin.query_x);
            ref_y = longint'(vin.query_y);
            winding = '0;
            settled = 1'b0;
            settled_code = pip_pkg::LOC_SHORT;
            vcount = 1;
        end
        else
        begin
            visit_edge(last_x, last_y, vx, vy);
            last_x = vx;
            last_y = vy;
            if (vcount < 3)
                vcount++;
        end
        if (!vin.last_vertex)
            return;
        // close the ring back to the first vertex
        if (vcount >= 2)
            visit_edge(vx, vy, poly_x0, poly_y0);
        if (vcount < 3)
            expect_loc(pip_pkg::LOC_SHORT);
        else if (settled)
            expect_loc(settled_code);
        else
            expect_loc((winding == '0) ? pip_pkg::LOC_OUTSIDE : pip_pkg::LOC_INSIDE);
        vcount = 0;
    endfunction

    assign pending = loc_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol = longint'(pip_pkg::TOL_RESET);
            vcount = 0;
            settled = 1'b0;
            settled_code = pip_pkg::LOC_SHORT;
            winding = '0;
            poly_x0 = 0; poly_y0 = 0; last_x = 0; last_y = 0; ref_x = 0; ref_y = 0;
            fail_count = 0;
            loc_queue.delete();
        end
        else
        begin
            if (cfg_we)
                tol = longint'(cfg_data);
            if (vin.valid && vin.ready)
                take_vertex();
            if (loc.valid && loc.ready)
            begin
                if (loc_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected location %0d", loc.location);
                end
                else
                begin
                    if (loc.location !== loc_queue[0])
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("location mismatch: expected %0d, got %0d",
                                     loc_queue[0], loc.location);
                    end
                    void'(loc_queue.pop_front());
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: point-in-polygon test bench
// Streams directed and random polygons under random stalls and several
// tolerance settings; the checker predicts and compares every location.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pip_pkg::TOL_WIDTH-1:0] cfg_data;
    int                            fail_count;
    int                            pending;
    int                            sent;
    bit                            calm;      // no idling on either side
    bit                            hold_req;  // ask the receiver for a long hold-off

    pip_vertex_if #(.COORD_WIDTH(48)) vin_if();
    pip_loc_if                        loc_if();

    point_in_polygon_test #(.COORD_WIDTH(48)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vin      (vin_if),
        .loc      (loc_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    pip_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .vin        (vin_if),
        .loc        (loc_if),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Send one vertex request and hold it until accepted.
    task automatic put_vertex(longint vx, longint vy, longint qx, longint qy,
                              bit first, bit last);
        if (!calm && $urandom_range(0, 99) < 8)
        begin
            vin_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        vin_if.valid        <= 1'b1;
        vin_if.vertex_x     <= vx[47:0];
        vin_if.vertex_y     <= vy[47:0];
        vin_if.query_x      <= qx[47:0];
        vin_if.query_y      <= qy[47:0];
        vin_if.first_vertex <= first;
        vin_if.last_vertex  <= last;
        @(posedge clk);
        while (!vin_if.ready)
            @(posedge clk);
        sent++;
    endtask

    // Drop valid and wait for every expected location, plus the tail of an
    // edge test that produces no result.
    task automatic drain();
        vin_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [pip_pkg::TOL_WIDTH-1:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Send a whole polygon with the query taken on the first vertex.
    task automatic put_ring(longint xs[$], longint ys[$], longint qx, longint qy);
        for (int i = 0; i < xs.size(); i++)
            put_vertex(xs[i], ys[i], qx, qy, i == 0, i == xs.size() - 1);
    endtask

    function automatic longint rand_full();
        logic [63:0] r;
        logic [47:0] v;
        r = {$urandom, $urandom};
        v = r[47:0];
        return longint'($signed(v));
    endfunction

    function automatic longint rand_grid();
        longint g;
        g = longint'($urandom_range(0, 16)) - 8;
        g = g <<< 16;
        if ($urandom_range(0, 3) == 0)
            g += longint'($urandom_range(0, 14)) - 7;
        return g;
    endfunction

    // Random polygon: mostly small grid rings, queries on vertices, edge midpoints and random points.
    task automatic put_random_ring();
        longint xs[$], ys[$];
        longint qx, qy;
        int     n, k;
        bit     full;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        full = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++)
        begin
            xs = {xs, full ? rand_full() : rand_grid()};
            ys = {ys, full ? rand_full() : rand_grid()};
        end
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 3))
            0: begin qx = xs[k]; qy = ys[k]; end
            1: begin
                qx = (xs[k] >>> 1) + (xs[(k + 1) % n] >>> 1);
                qy = (ys[k] >>> 1) + (ys[(k + 1) % n] >>> 1);
            end
            default: begin
                qx = full ? rand_full() : rand_grid();
                qy = full ? rand_full() : rand_grid();
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            bit f, l;
            f = (i == 0);
            l = (i == n - 1);
            // broken sequences: lost or stray first and last flags
            if ($urandom_range(0, 39) == 0) f = ~f;
            if ($urandom_range(0, 39) == 0) l = ~l;
            put_vertex(xs[i], ys[i], full ? rand_full() : qx,
                       full ? rand_full() : qy, f, l);
        end
    endtask

    task automatic run_random(int count);
        int stop;
        stop = sent + count;
        while (sent < stop)
            put_random_ring();
    endtask

    localparam longint U     = 64'sd65536;
    localparam longint C_MAX = 64'sd140737488355327;
    localparam longint C_MIN = -64'sd140737488355328;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        vin_if.valid = 1'b0;
        vin_if.vertex_x = '0;
        vin_if.vertex_y = '0;
        vin_if.query_x = '0;
        vin_if.query_y = '0;
        vin_if.first_vertex = 1'b0;
        vin_if.last_vertex = 1'b0;
        sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no first flag after reset, short rings, each location
        put_vertex(0, 0, U, U, 1'b0, 1'b0);
        put_vertex(4 * U, 0, U, U, 1'b0, 1'b0);
        put_vertex(0, 4 * U, U, U, 1'b0, 1'b1);
        put_vertex(U, U, 0, 0, 1'b1, 1'b1);
        put_ring('{0, 4 * U}, '{0, 0}, 2 * U, 0);
        put_ring('{0, 4 * U, 0}, '{0, 0, 4 * U}, 9 * U, U);
        put_ring('{0, 4 * U, 0}, '{0, 0, 4 * U}, 4 * U, 0);
        put_ring('{0, 4 * U, 0}, '{0, 0, 4 * U}, 2 * U, 0);
        put_ring('{0, 4 * U, 4 * U, 0}, '{0, 0, 4 * U, 4 * U}, 2 * U, 2 * U);
        put_ring('{C_MIN, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MAX}, C_MAX, 0);
        put_ring('{C_MAX, C_MIN, C_MIN}, '{C_MAX, C_MAX, C_MIN}, C_MIN, C_MIN);

        // receiver holds off while requests keep coming
        hold_req = 1'b1;
        run_random(40);

        // sender pauses until every location is back
        drain();
        calm = 1'b1;
        run_random(150);
        calm = 1'b0;

        set_tolerance('0);
        put_ring('{0, 4 * U, 0}, '{0, 0, 4 * U}, 2 * U, 0);
        run_random(200);
        set_tolerance(21'd1048576);
        run_random(200);
        set_tolerance(21'h1FFFFF & 21'd65536);
        run_random(200);
        set_tolerance(21'($urandom_range(1, 1048576)));
        run_random(200);

        drain();
        if (fail_count == 0)
            $display("[point_in_polygon_test] OK");
        else
            $display("[point_in_polygon_test] ERROR");
        $finish;
    end

    initial
    begin
        loc_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                loc_if.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                loc_if.ready <= calm || ($urandom_range(0, 99) >= 8);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #(8 * 2000000);
        $display("[point_in_polygon_test] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
